>>> hw/rtl/dual_modular_polynomial_hash_macros.svh
// Assertion macros shared by the hash block.
`ifndef DUAL_MODULAR_POLYNOMIAL_HASH_MACROS_SVH
`define DUAL_MODULAR_POLYNOMIAL_HASH_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DMPH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dmph assertion failed");

// Next-cycle implication, checked out of reset.
`define DMPH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dmph assertion failed");

`endif

>>> hw/rtl/dmph_pkg.sv
// Constants and types shared by the dual-modulus hash modules.
package dmph_pkg;

  localparam logic [29:0] ModFirst  = 30'd1000000007;
  localparam logic [29:0] ModSecond = 30'd1000000009;
  localparam logic [29:0] MixFactor = 30'd1000000014;
  localparam logic [29:0] BaseReset = 30'd100003;

  // register indexes on the config port
  localparam logic CfgFirstBase  = 1'b0;
  localparam logic CfgSecondBase = 1'b1;

  // one byte request handed to the residue units
  typedef struct packed {
    logic       fire;
    logic       last;
    logic [7:0] byte_val;
  } dmph_item_t;

endpackage

>>> hw/rtl/dmph_mac.sv
// Modular multiply-accumulate unit: one residue, one base, one byte per cycle while not busy.
module dmph_mac import dmph_pkg::*; #(
  parameter logic [29:0] Modulus = 30'd1000000007
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        base_we_i,
  input  logic [29:0] base_i,
  input  dmph_item_t  item_i,
  output logic        busy_o,
  output logic [29:0] residue_o
);

  localparam logic [31:0] Mod1x = 32'(Modulus);
  localparam logic [31:0] Mod2x = 32'(2 * 64'(Modulus));
  localparam logic [31:0] Mod3x = 32'(3 * 64'(Modulus));

  // k * 2^30 mod M and k * 2^35 mod M, folded back into the low 30 bits
  logic [29:0] tbl_lo [32];
  logic [29:0] tbl_hi [32];

  for (genvar k = 0; k < 32; k++) begin : g_tbl
    assign tbl_lo[k] = 30'((64'(k) << 30) % 64'(Modulus));
    assign tbl_hi[k] = 30'((64'(k) << 35) % 64'(Modulus));
  end

  function automatic logic [29:0] fold_mod(input logic [39:0] s);
    logic [9:0]  hi;
    logic [31:0] r;
    hi = s[39:30];
    r  = 32'(s[29:0]) + 32'(tbl_lo[hi[4:0]]) + 32'(tbl_hi[hi[9:5]]);
    if (r >= Mod3x) begin
      r = r - Mod3x;
    end else if (r >= Mod2x) begin
      r = r - Mod2x;
    end else if (r >= Mod1x) begin
      r = r - Mod1x;
    end
    return r[29:0];
  endfunction

  // pow_k holds base * 2^(8k) mod M, so residue * base splits into byte digits
  logic [29:0] res_q, res_d;
  logic [29:0] pow0_q, pow1_q, pow2_q, pow3_q;
  logic [1:0]  step_q, step_d;
  logic [29:0] base_red;
  logic [29:0] pow_src, pow_next;
  logic [37:0] pp0, pp1, pp2, pp3;
  logic [39:0] mac_sum;
  logic [29:0] mac_res;

  assign base_red = (base_i >= Modulus) ? base_i - Modulus : base_i;

  always_comb begin
    case (step_q)
      2'd1:    pow_src = pow0_q;
      2'd2:    pow_src = pow1_q;
      default: pow_src = pow2_q;
    endcase
    pow_next = fold_mod({2'b00, pow_src, 8'h00});
  end

  assign pp0 = 38'(res_q[7:0])   * 38'(pow0_q);
  assign pp1 = 38'(res_q[15:8])  * 38'(pow1_q);
  assign pp2 = 38'(res_q[23:16]) * 38'(pow2_q);
  assign pp3 = 38'(res_q[29:24]) * 38'(pow3_q);

  assign mac_sum = 40'(pp0) + 40'(pp1) + 40'(pp2) + 40'(pp3) + 40'(item_i.byte_val);
  assign mac_res = fold_mod(mac_sum);

  always_comb begin
    res_d  = res_q;
    step_d = step_q;
    if (item_i.fire) begin
      res_d = item_i.last ? '0 : mac_res;
    end
    if (base_we_i) begin
      step_d = 2'd1;
    end else if (step_q != 2'd0) begin
      step_d = step_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q  <= '0;
      step_q <= 2'd1;
      pow0_q <= BaseReset;
    end else begin
      res_q  <= res_d;
      step_q <= step_d;
      if (base_we_i) begin
        pow0_q <= base_red;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!base_we_i) begin
      if (step_q == 2'd1) begin
        pow1_q <= pow_next;
      end
      if (step_q == 2'd2) begin
        pow2_q <= pow_next;
      end
      if (step_q == 2'd3) begin
        pow3_q <= pow_next;
      end
    end
  end

  assign busy_o    = (step_q != 2'd0);
  assign residue_o = mac_res;

endmodule

>>> hw/rtl/dual_modular_polynomial_hash.sv
// Dual-modulus polynomial frame hash.
// Input channel: one frame byte per request (byte_value_i, frame_end_i) on
// in_valid_i / in_ready_o; frame_end_i marks the last byte of a frame.
// Output channel: one frame_hash_o per frame on out_valid_o / out_ready_i,
// equal to h1 * 1000000014 + h2 with h1, h2 the residues mod 1000000007 and
// 1000000009 after the last byte. Both residues then restart from zero.
// Config: cfg_we_i writes cfg_data_i into base 0 (first) or 1 (second).
// Throughput: one byte per cycle unless the units are busy or the receiver stalls;
// each residue unit does one modular multiply-accumulate per cycle on a 30x30
// product split into byte digits. The last byte passes the input register, the
// residue stage and the mixing multiply stage before the hash is valid.
// After reset and after every base write, in_ready_o stays low while each unit
// builds base * 2^8k mod M for k = 1..3.
// When the receiver stalls, one finished hash waits at the output and one in
// the residue stage; once both are full the input register holds its byte and
// in_ready_o drops until the output is taken.
// Reset clears the residues, the pipeline valids and loads both bases with 100003.
`include "dual_modular_polynomial_hash_macros.svh"

module dual_modular_polynomial_hash import dmph_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_value_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [59:0] frame_hash_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [29:0] cfg_data_i
);

  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        fin_vld_q;
  logic [29:0] fin1_q, fin2_q;
  logic        out_vld_q;
  logic [59:0] hash_q;

  logic        out_free, fin_free, s0_fire, in_fire;
  logic        busy1, busy2;
  logic [29:0] res1, res2;
  dmph_item_t  item;

  assign out_free   = !out_vld_q || out_ready_i;
  assign fin_free   = !fin_vld_q || out_free;
  assign s0_fire    = in_vld_q && fin_free;
  assign in_ready_o = !busy1 && !busy2 && (!in_vld_q || s0_fire);
  assign in_fire    = in_valid_i && in_ready_o;

  assign item.fire     = s0_fire;
  assign item.last     = in_last_q;
  assign item.byte_val = in_byte_q;

  dmph_mac #(.Modulus(ModFirst)) u_mac_first (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .base_we_i (cfg_we_i && (cfg_index_i == CfgFirstBase)),
    .base_i    (cfg_data_i),
    .item_i    (item),
    .busy_o    (busy1),
    .residue_o (res1)
  );

  dmph_mac #(.Modulus(ModSecond)) u_mac_second (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .base_we_i (cfg_we_i && (cfg_index_i == CfgSecondBase)),
    .base_i    (cfg_data_i),
    .item_i    (item),
    .busy_o    (busy2),
    .residue_o (res2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      fin_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_fire) begin
        in_vld_q <= 1'b1;
      end else if (s0_fire) begin
        in_vld_q <= 1'b0;
      end
      if (s0_fire && in_last_q) begin
        fin_vld_q <= 1'b1;
      end else if (out_free) begin
        fin_vld_q <= 1'b0;
      end
      if (fin_vld_q && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= byte_value_i;
      in_last_q <= frame_end_i;
    end
    if (s0_fire && in_last_q) begin
      fin1_q <= res1;
      fin2_q <= res2;
    end
    if (fin_vld_q && out_free) begin
      hash_q <= 60'(fin1_q) * 60'(MixFactor) + 60'(fin2_q);
    end
  end

  assign out_valid_o  = out_vld_q;
  assign frame_hash_o = hash_q;

  `DMPH_ASSERT_NEXT(a_cfg_blocks_input, cfg_we_i, !in_ready_o)
  `DMPH_ASSERT_NEXT(a_last_reaches_fin, s0_fire && in_last_q, fin_vld_q)
  `DMPH_ASSERT_NEXT(a_fin_holds, fin_vld_q && !out_free,
                    fin_vld_q && $stable(fin1_q) && $stable(fin2_q))
  `DMPH_ASSERT_NOW(a_busy_no_accept, busy1 || busy2, !in_fire)

endmodule

>>> tb/dual_modular_polynomial_hash_tb.sv
// Self-checking testbench for the dual-modulus polynomial frame hash.
`timescale 1ns / 1ps

module dual_modular_polynomial_hash_tb import dmph_pkg::*; ();

  localparam int ClkPeriod    = 8;
  localparam int SettleCycles = 8;
  localparam int StallLimit   = 4000;
  localparam int PhaseBytes   = 135;
  localparam logic [29:0] BaseMax = 30'h3FFFFFFF;

  // Tracks both residues and the bases, and holds the hashes still owed by the block.
  class frame_hash_tracker;
    logic [29:0] base_a;
    logic [29:0] base_b;
    logic [29:0] res_a;
    logic [29:0] res_b;
    logic [59:0] pending_hashes[$];
    int unsigned mismatches;

    function new();
      base_a = BaseReset;
      base_b = BaseReset;
      res_a = '0;
      res_b = '0;
      mismatches = 0;
    endfunction

    function void set_base(logic idx, logic [29:0] value);
      if (idx == CfgFirstBase) begin
        base_a = value;
      end else begin
        base_b = value;
      end
    endfunction

    static function logic [29:0] mac_reduce(logic [29:0] acc, logic [29:0] mul,
                                            logic [7:0] b, logic [29:0] modulus);
      logic [63:0] t;
      t = 64'(acc) * 64'(mul) + 64'(b);
      return 30'(t % 64'(modulus));
    endfunction

    function void fold_byte(logic [7:0] b, logic last);
      logic [63:0] mixed;
      res_a = mac_reduce(res_a, base_a, b, ModFirst);
      res_b = mac_reduce(res_b, base_b, b, ModSecond);
      if (last) begin
        mixed = 64'(res_a) * 64'(MixFactor) + 64'(res_b);
        pending_hashes.push_back(mixed[59:0]);
        res_a = '0;
        res_b = '0;
      end
    endfunction

    task flag_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatches++;
    endtask

    task compare_hash(logic [59:0] got);
      logic [59:0] want;
      if (pending_hashes.size() == 0) begin
        flag_mismatch($sformatf("frame_hash %h with no frame outstanding", got));
      end else begin
        want = pending_hashes.pop_front();
        if (got !== want) begin
          flag_mismatch($sformatf("frame_hash got %h expected %h", got, want));
        end
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  byte_value_i;
  logic        frame_end_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [59:0] frame_hash_o;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [29:0] cfg_data_i;

  frame_hash_tracker tracker = new();
  bit src_steady;
  bit sink_steady;
  int unsigned quiet_cycles;

  dual_modular_polynomial_hash u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .byte_value_i (byte_value_i),
    .frame_end_i  (frame_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .frame_hash_o (frame_hash_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // mostly no gap or a short one, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [29:0] pick_base();
    case ($urandom_range(0, 7))
      0: return 30'd0;
      1: return 30'd1;
      2: return BaseMax;
      3: return ModFirst;
      4: return ModSecond;
      default: return 30'($urandom_range(2, 32'h3FFFFFFF));
    endcase
  endfunction

  function automatic int unsigned pick_frame_len();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(1, 8);
    if (r < 9) return $urandom_range(9, 24);
    return $urandom_range(25, 64);
  endfunction

  // Observe both channels on the rising edge; also the no-progress watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        tracker.fold_byte(byte_value_i, frame_end_i);
      end
      if (out_valid_o && out_ready_i) begin
        tracker.compare_hash(frame_hash_o);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Receiver: ready with random stalls unless a steady stretch is requested.
  initial begin
    int unsigned g;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk_i);
      g = pick_gap();
      if (!sink_steady && g != 0) begin
        out_ready_i <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned g;
    g = src_steady ? 0 : pick_gap();
    @(negedge clk_i);
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    byte_value_i <= b;
    frame_end_i  <= last;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
  endtask

  // Stop sending, let every owed hash come back, then let the pipeline empty.
  task automatic go_quiet();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.pending_hashes.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_base(logic idx, logic [29:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_base(idx, value);
  endtask

  task automatic send_frame(int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      // occasional base change in the middle of a frame
      if (len >= 4 && i == len / 2 && $urandom_range(0, 29) == 0) begin
        go_quiet();
        write_base(1'($urandom_range(0, 1)), pick_base());
      end
      send_byte(pick_byte(), i == len - 1);
    end
  endtask

  task automatic run_phase(logic [29:0] ba, logic [29:0] bb, bit steady_in, bit steady_out);
    int unsigned sent;
    go_quiet();
    write_base(CfgFirstBase, ba);
    write_base(CfgSecondBase, bb);
    src_steady = steady_in;
    sink_steady = steady_out;
    sent = 0;
    while (sent < PhaseBytes) begin
      int unsigned len;
      len = pick_frame_len();
      send_frame(len);
      sent += len;
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    byte_value_i = '0;
    frame_end_i  = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = CfgFirstBase;
    cfg_data_i   = '0;
    src_steady   = 1'b0;
    sink_steady  = 1'b0;
    quiet_cycles = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset bases: one-byte frames at the byte extremes, then short frames
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    repeat (3) send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    // bases of 0 and 1 written part way through a frame
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    go_quiet();
    write_base(CfgFirstBase, 30'd0);
    write_base(CfgSecondBase, 30'd1);
    send_byte(8'h04, 1'b1);
    // bases at and above the moduli
    go_quiet();
    write_base(CfgFirstBase, BaseMax);
    write_base(CfgSecondBase, BaseMax);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    go_quiet();
    write_base(CfgFirstBase, ModFirst);
    write_base(CfgSecondBase, ModSecond);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b1);

    run_phase(BaseReset, BaseReset, 1'b0, 1'b0);
    run_phase(30'd2, 30'd2, 1'b0, 1'b1);
    run_phase(ModFirst - 30'd1, ModSecond - 30'd1, 1'b1, 1'b0);
    run_phase(30'd0, 30'd1, 1'b0, 1'b0);
    run_phase(30'd1, 30'd0, 1'b1, 1'b1);
    run_phase(BaseMax, BaseMax, 1'b0, 1'b0);
    run_phase(ModFirst, ModSecond, 1'b0, 1'b1);
    run_phase(pick_base(), pick_base(), 1'b1, 1'b0);
    run_phase(30'($urandom_range(2, 32'h3FFFFFFF)), 30'($urandom_range(2, 32'h3FFFFFFF)),
              1'b0, 1'b0);

    go_quiet();
    repeat (SettleCycles) @(posedge clk_i);
    if (tracker.pending_hashes.size() != 0) begin
      tracker.flag_mismatch($sformatf("%0d hashes never arrived",
                                      tracker.pending_hashes.size()));
    end
    if (tracker.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
